@@ src/idll_pkg.sv @@
// ----------------------------------------------------------------------------
// idll_pkg
// Shared widths, command codes and status codes of the indexed doubly
// linked list.
// ----------------------------------------------------------------------------
package idll_pkg;

    // Default sizing of the node store
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the request and response channels
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0] cmd_code_t;

    // Command codes
    localparam cmd_code_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_code_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_code_t CMD_INSERT     = 3'd2;
    localparam cmd_code_t CMD_POP_FRONT  = 3'd3;
    localparam cmd_code_t CMD_POP_BACK   = 3'd4;
    localparam cmd_code_t CMD_ERASE      = 3'd5;
    localparam cmd_code_t CMD_READ       = 3'd6;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage

@@ src/idll_if.sv @@
// ----------------------------------------------------------------------------
// idll_if
// Valid/ready channels of the indexed doubly linked list: the command
// request channel and the response channel.
// ----------------------------------------------------------------------------

// Command request channel
interface idll_req_if;
    logic                                valid;
    logic                                ready;
    logic [idll_pkg::CMD_W-1:0]          cmd;
    logic signed [idll_pkg::VALUE_W-1:0] value;
    logic [idll_pkg::POS_W-1:0]          position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

// Response channel
interface idll_rsp_if;
    logic                                valid;
    logic                                ready;
    idll_pkg::status_t                   status;
    logic [idll_pkg::COUNT_W-1:0]        count;
    logic signed [idll_pkg::VALUE_W-1:0] read_value;

    modport source (output valid, output status, output count, output read_value, input ready);
    modport sink   (input valid, input status, input count, input read_value, output ready);
endinterface

@@ src/indexed_doubly_linked_list.sv @@
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Bounded ordered list of signed words, kept as a doubly linked list in a
// node store with a free chain, driven by a small command sequencer.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one response. Push passes
// through decode, take and done; pop through decode, give and done; a
// rejected or unused command goes from decode straight to done. Insert,
// erase and read walk from the head or the tail, whichever is nearer, at
// one node per cycle through the next/prev store read port, then pass
// through link: a read goes on to done, an erase through give and an
// insert through take and mid2. A finished response waits in its output
// register, so the next request can be taken before it is read; the
// sequencer only waits in its last state while an earlier response is
// still unread.
// Never-used nodes are tracked by a high-water mark, so no clearing pass is
// needed after reset.
module indexed_doubly_linked_list #(
    parameter int CAPACITY   = idll_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = idll_pkg::DATA_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    idll_req_if.sink        req,
    idll_rsp_if.source      rsp
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > idll_pkg::POS_W) ? CNT_W : idll_pkg::POS_W;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_WALK   = 8'b0000_0100,
        S_LINK   = 8'b0000_1000,
        S_TAKE   = 8'b0001_0000,
        S_MID2   = 8'b0010_0000,
        S_GIVE   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD_FRONT,
        OP_ADD_BACK,
        OP_ADD_MID,
        OP_DROP_FRONT,
        OP_DROP_BACK,
        OP_DROP_MID,
        OP_READ
    } op_t;

    // Node store
    logic signed [DATA_WIDTH-1:0] node_value [CAPACITY];
    ptr_t                         node_next  [CAPACITY];
    ptr_t                         node_prev  [CAPACITY];

    // Control state
    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    ptr_t   head_reg, head_next;
    ptr_t   tail_reg, tail_next;
    ptr_t   free_reg, free_next;
    cnt_t   cnt_reg, cnt_next;
    cnt_t   hwm_reg, hwm_next;
    logic   out_valid_reg, out_valid_next;

    // Datapath registers
    idll_pkg::cmd_code_t            cmd_reg;
    logic signed [DATA_WIDTH-1:0]   val_reg;
    logic [idll_pkg::POS_W-1:0]     pos_reg;
    ptr_t                           wp_reg, wp_next;
    ptr_t                           steps_reg, steps_next;
    logic                           fwd_reg, fwd_next;
    logic                           first_reg, first_next;
    ptr_t                           target_reg, target_next;
    ptr_t                           pred_reg, pred_next;
    ptr_t                           new_node_reg, new_node_next;
    idll_pkg::status_t              status_reg, status_next;
    logic signed [DATA_WIDTH-1:0]   rd_reg, rd_next;
    idll_pkg::status_t              out_status_reg;
    logic [idll_pkg::COUNT_W-1:0]   out_count_reg;
    logic signed [idll_pkg::VALUE_W-1:0] out_rd_reg;

    // Store ports
    ptr_t                         rd_addr;
    logic signed [DATA_WIDTH-1:0] value_q;
    ptr_t                         next_q;
    ptr_t                         prev_q;
    logic                         vl_we, nx_we, pv_we;
    ptr_t                         vl_wa, nx_wa, pv_wa;
    logic signed [DATA_WIDTH-1:0] vl_wd;
    ptr_t                         nx_wd, pv_wd;

    // Decode and helper signals
    logic              req_fire;
    logic              load_out;
    op_t               dec_op;
    idll_pkg::status_t dec_status;
    logic [CMP_W-1:0]  cnt_ext, pos_ext;
    logic              full, cnt_zero, cnt_one;
    logic              from_head;
    ptr_t              walk_cur;
    logic              fresh;
    ptr_t              free_inc;

    assign req_fire  = req.valid & req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.count      = out_count_reg;
    assign rsp.read_value = out_rd_reg;

    assign cnt_ext   = CMP_W'(cnt_reg);
    assign pos_ext   = CMP_W'(pos_reg);
    assign full      = (cnt_reg == CNT_W'(CAPACITY));
    assign cnt_zero  = (cnt_reg == '0);
    assign cnt_one   = (cnt_reg == CNT_W'(1));
    assign from_head = (pos_ext < (cnt_ext >> 1));
    assign walk_cur  = first_reg ? wp_reg : (fwd_reg ? next_q : prev_q);

    // Fresh nodes sit at the high-water mark and chain to the next index
    assign fresh    = (hwm_reg != CNT_W'(CAPACITY)) && (CNT_W'(free_reg) == hwm_reg);
    assign free_inc = (free_reg == PTR_W'(CAPACITY - 1)) ? '0 : PTR_W'(free_reg + PTR_W'(1));

    // Decode the command against the current count
    always_comb
    begin
        dec_op     = OP_NONE;
        dec_status = idll_pkg::ST_OK;
        unique case (cmd_reg)
            idll_pkg::CMD_PUSH_FRONT:
            begin
                if (full) dec_status = idll_pkg::ST_FULL;
                else      dec_op     = OP_ADD_FRONT;
            end
            idll_pkg::CMD_PUSH_BACK:
            begin
                if (full)          dec_status = idll_pkg::ST_FULL;
                else if (cnt_zero) dec_op     = OP_ADD_FRONT;
                else               dec_op     = OP_ADD_BACK;
            end
            idll_pkg::CMD_INSERT:
            begin
                if (pos_ext > cnt_ext)       dec_status = idll_pkg::ST_RANGE;
                else if (full)               dec_status = idll_pkg::ST_FULL;
                else if (pos_ext == '0)      dec_op     = OP_ADD_FRONT;
                else if (pos_ext == cnt_ext) dec_op     = OP_ADD_BACK;
                else                         dec_op     = OP_ADD_MID;
            end
            idll_pkg::CMD_POP_FRONT:
            begin
                if (cnt_zero) dec_status = idll_pkg::ST_EMPTY;
                else          dec_op     = OP_DROP_FRONT;
            end
            idll_pkg::CMD_POP_BACK:
            begin
                if (cnt_zero)     dec_status = idll_pkg::ST_EMPTY;
                else if (cnt_one) dec_op     = OP_DROP_FRONT;
                else              dec_op     = OP_DROP_BACK;
            end
            idll_pkg::CMD_ERASE:
            begin
                if (pos_ext >= cnt_ext)                      dec_status = idll_pkg::ST_RANGE;
                else if (pos_ext == '0)                      dec_op     = OP_DROP_FRONT;
                else if (pos_ext + CMP_W'(1) == cnt_ext)     dec_op     = OP_DROP_BACK;
                else                                         dec_op     = OP_DROP_MID;
            end
            idll_pkg::CMD_READ:
            begin
                if (pos_ext >= cnt_ext) dec_status = idll_pkg::ST_RANGE;
                else                    dec_op     = OP_READ;
            end
            default:
            begin
                dec_op     = OP_NONE;
                dec_status = idll_pkg::ST_OK;
            end
        endcase
    end

    // Sequence one command through walk, relink and response
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_next      = free_reg;
        cnt_next       = cnt_reg;
        hwm_next       = hwm_reg;
        wp_next        = wp_reg;
        steps_next     = steps_reg;
        fwd_next       = fwd_reg;
        first_next     = first_reg;
        target_next    = target_reg;
        pred_next      = pred_reg;
        new_node_next  = new_node_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        load_out       = 1'b0;
        rd_addr        = free_reg;
        vl_we          = 1'b0;
        vl_wa          = free_reg;
        vl_wd          = val_reg;
        nx_we          = 1'b0;
        nx_wa          = free_reg;
        nx_wd          = head_reg;
        pv_we          = 1'b0;
        pv_wa          = free_reg;
        pv_wd          = tail_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire) state_next = S_DECODE;
            end

            S_DECODE:
            begin
                op_next     = dec_op;
                status_next = dec_status;
                rd_next     = '0;
                wp_next     = from_head ? head_reg : tail_reg;
                steps_next  = from_head ? PTR_W'(pos_ext)
                                        : PTR_W'(cnt_ext - pos_ext - CMP_W'(1));
                fwd_next    = from_head;
                first_next  = 1'b1;
                case (dec_op) inside
                    OP_ADD_FRONT, OP_ADD_BACK:
                    begin
                        rd_addr    = free_reg;
                        state_next = S_TAKE;
                    end
                    OP_DROP_FRONT:
                    begin
                        rd_addr     = head_reg;
                        target_next = head_reg;
                        state_next  = S_GIVE;
                    end
                    OP_DROP_BACK:
                    begin
                        rd_addr     = tail_reg;
                        target_next = tail_reg;
                        state_next  = S_GIVE;
                    end
                    OP_ADD_MID, OP_DROP_MID, OP_READ:
                    begin
                        state_next = S_WALK;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Follow one link per cycle; the last read fetches the target node
            S_WALK:
            begin
                rd_addr    = walk_cur;
                wp_next    = walk_cur;
                first_next = 1'b0;
                if (steps_reg == '0)
                begin
                    target_next = walk_cur;
                    state_next  = S_LINK;
                end
                else
                begin
                    steps_next = PTR_W'(steps_reg - PTR_W'(1));
                end
            end

            S_LINK:
            begin
                pred_next = prev_q;
                case (op_reg)
                    OP_READ:
                    begin
                        rd_next    = value_q;
                        state_next = S_DONE;
                    end
                    OP_ADD_MID:
                    begin
                        rd_addr    = free_reg;
                        state_next = S_TAKE;
                    end
                    default:
                    begin
                        // unlink the target from its neighbours
                        nx_we      = 1'b1;
                        nx_wa      = prev_q;
                        nx_wd      = next_q;
                        pv_we      = 1'b1;
                        pv_wa      = next_q;
                        pv_wd      = prev_q;
                        state_next = S_GIVE;
                    end
                endcase
            end

            // Take the node at the head of the free chain and link it in
            S_TAKE:
            begin
                free_next     = fresh ? free_inc : next_q;
                hwm_next      = fresh ? CNT_W'(hwm_reg + CNT_W'(1)) : hwm_reg;
                new_node_next = free_reg;
                vl_we         = 1'b1;
                vl_wa         = free_reg;
                vl_wd         = val_reg;
                case (op_reg)
                    OP_ADD_FRONT:
                    begin
                        if (cnt_zero)
                        begin
                            head_next = free_reg;
                            tail_next = free_reg;
                        end
                        else
                        begin
                            nx_we     = 1'b1;
                            nx_wa     = free_reg;
                            nx_wd     = head_reg;
                            pv_we     = 1'b1;
                            pv_wa     = head_reg;
                            pv_wd     = free_reg;
                            head_next = free_reg;
                        end
                        cnt_next   = CNT_W'(cnt_reg + CNT_W'(1));
                        state_next = S_DONE;
                    end
                    OP_ADD_BACK:
                    begin
                        pv_we      = 1'b1;
                        pv_wa      = free_reg;
                        pv_wd      = tail_reg;
                        nx_we      = 1'b1;
                        nx_wa      = tail_reg;
                        nx_wd      = free_reg;
                        tail_next  = free_reg;
                        cnt_next   = CNT_W'(cnt_reg + CNT_W'(1));
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        nx_we      = 1'b1;
                        nx_wa      = free_reg;
                        nx_wd      = target_reg;
                        pv_we      = 1'b1;
                        pv_wa      = free_reg;
                        pv_wd      = pred_reg;
                        state_next = S_MID2;
                    end
                endcase
            end

            // Point the neighbours at the inserted node
            S_MID2:
            begin
                nx_we      = 1'b1;
                nx_wa      = pred_reg;
                nx_wd      = new_node_reg;
                pv_we      = 1'b1;
                pv_wa      = target_reg;
                pv_wd      = new_node_reg;
                cnt_next   = CNT_W'(cnt_reg + CNT_W'(1));
                state_next = S_DONE;
            end

            // Move the end pointers of a front or back drop and return the node to the free chain
            S_GIVE:
            begin
                case (op_reg)
                    OP_DROP_FRONT:
                    begin
                        if (cnt_one)
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else
                        begin
                            head_next = next_q;
                        end
                    end
                    OP_DROP_BACK:
                    begin
                        tail_next = prev_q;
                    end
                    default:
                    begin
                        head_next = head_reg;
                    end
                endcase
                nx_we      = 1'b1;
                nx_wa      = target_reg;
                nx_wd      = free_reg;
                free_next  = target_reg;
                cnt_next   = CNT_W'(cnt_reg - CNT_W'(1));
                state_next = S_DONE;
            end

            // Hand the response to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)       out_valid_next = 1'b1;
        else if (rsp.ready) out_valid_next = 1'b0;
        else                out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NONE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= '0;
            cnt_reg       <= '0;
            hwm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            cnt_reg       <= cnt_next;
            hwm_reg       <= hwm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg <= req.cmd;
            val_reg <= DATA_WIDTH'(req.value);
            pos_reg <= req.position;
        end
        wp_reg       <= wp_next;
        steps_reg    <= steps_next;
        fwd_reg      <= fwd_next;
        first_reg    <= first_next;
        target_reg   <= target_next;
        pred_reg     <= pred_next;
        new_node_reg <= new_node_next;
        status_reg   <= status_next;
        rd_reg       <= rd_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= idll_pkg::COUNT_W'(cnt_reg);
            out_rd_reg     <= idll_pkg::VALUE_W'(rd_reg);
        end
    end

    // Value store
    always_ff @(posedge clk)
    begin
        if (vl_we) node_value[vl_wa] <= vl_wd;
        value_q <= node_value[rd_addr];
    end

    // Forward link store
    always_ff @(posedge clk)
    begin
        if (nx_we) node_next[nx_wa] <= nx_wd;
        next_q <= node_next[rd_addr];
    end

    // Backward link store
    always_ff @(posedge clk)
    begin
        if (pv_we) node_prev[pv_wa] <= pv_wd;
        prev_q <= node_prev[rd_addr];
    end

endmodule
